// File: design/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Request and result types, status codes and character tables for the
// HTTP response header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int LEN_W  = 31;
    localparam int BODY_W = 11;

    localparam logic [LEN_W-1:0] LEN_SAT       = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1024 * 1024);

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_SERVER_ERROR = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_BUSY         = 3'd3;
    localparam logic [2:0] ST_INVALID      = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int LINE_200_LEN = 15;
    localparam int LINE_404_LEN = 22;
    localparam int LINE_503_LEN = 32;
    localparam int NAME_LEN     = 14;

    localparam logic [8*LINE_200_LEN-1:0] LINE_200 = "http/1.1 200 ok";
    localparam logic [8*LINE_404_LEN-1:0] LINE_404 = "http/1.1 404 not found";
    localparam logic [8*LINE_503_LEN-1:0] LINE_503 = "http/1.1 503 service unavailable";
    localparam logic [8*NAME_LEN-1:0]     HDR_NAME = "content-length";

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [LEN_W-1:0]  content_length;
        logic [BODY_W-1:0] body_offset;
        logic [BODY_W-1:0] body_bytes_here;
    } out_t;

    function automatic logic [7:0] lower8(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] line200_char(input logic [4:0] idx);
        logic [7:0] r;
        r = CH_NUL;
        if (int'(idx) < LINE_200_LEN)
        begin
            r = LINE_200[8*(LINE_200_LEN-1-int'(idx)) +: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] line404_char(input logic [4:0] idx);
        logic [7:0] r;
        r = CH_NUL;
        if (int'(idx) < LINE_404_LEN)
        begin
            r = LINE_404[8*(LINE_404_LEN-1-int'(idx)) +: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] line503_char(input logic [4:0] idx);
        return LINE_503[8*(LINE_503_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] r;
        r = CH_NUL;
        if (int'(idx) < NAME_LEN)
        begin
            r = HDR_NAME[8*(NAME_LEN-1-int'(idx)) +: 8];
        end
        return r;
    endfunction

endpackage

// File: design/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// http_response_header_parser
// Parses the first packet of an HTTP response byte by byte and reports the
// status, Content-Length, body offset and body bytes present on the last byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    hrhp_pkg::in_t  (byte, last)
//  out       source     out_valid / out_ready  hrhp_pkg::out_t (one per packet)
//  cfg       sink       cfg_we                 cfg_wdata (max content length)
//
//  One byte per cycle while the result is not stalled; a request passes
//  through the input register and then the parse stage, which loads the
//  result register on the last byte.
//  A stalled result holds the parse stage; the input register still takes a
//  request while it is empty or moving on.
//  Reset clears all packet state; max content length returns to 1048576.
// ----------------------------------------------------------------------------
module http_response_header_parser #(
    parameter int PACKET_BYTES    = 1024,
    parameter int VALUE_CHARS_MAX = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hrhp_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hrhp_pkg::out_t               out_data,
    input  logic                         cfg_we,
    input  logic [hrhp_pkg::LEN_W-1:0]   cfg_wdata
);

    localparam int POS_W = $clog2(PACKET_BYTES + 1);
    localparam int CNT_W = $clog2(VALUE_CHARS_MAX + 2);
    localparam int ACC_W = hrhp_pkg::LEN_W + 4;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_COLON,
        PH_SPACE,
        PH_DIGITS,
        PH_REST,
        PH_DONE,
        PH_FAIL
    } phase_t;

    logic                          in_vld_reg, in_vld_next;
    hrhp_pkg::in_t                 in_data_reg, in_data_next;
    logic                          out_vld_reg, out_vld_next;
    hrhp_pkg::out_t                out_data_reg, out_data_next;
    logic [hrhp_pkg::LEN_W-1:0]    max_len_reg, max_len_next;

    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [2:0]                    match_reg, match_next;
    logic                          after_nl_reg, after_nl_next;
    logic [3:0]                    name_idx_reg, name_idx_next;
    phase_t                        phase_reg, phase_next;
    logic [CNT_W-1:0]              vcnt_reg, vcnt_next;
    logic [hrhp_pkg::LEN_W-1:0]    acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic [23:0]                   recent_reg, recent_next;
    logic [1:0]                    since_reg, since_next;
    logic [2:0]                    found_reg, found_next;
    logic [POS_W-1:0]              term_end_reg  [3];
    logic [POS_W-1:0]              term_end_next [3];
    logic                          text_end_reg, text_end_next;

    logic advance;
    logic proc;

    assign advance   = !out_vld_reg || out_ready;
    assign proc      = in_vld_reg && advance;
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic [7:0]                 b;
        logic [7:0]                 lb;
        logic                       stop;
        logic                       do_val;
        phase_t                     v_phase;
        logic [CNT_W-1:0]           v_cnt;
        logic [ACC_W-1:0]           prod;
        logic [23:0]                t_recent;
        logic [1:0]                 t_since;
        logic [31:0]                w;
        logic [POS_W-1:0]           n;
        logic [POS_W-1:0]           e;
        logic [POS_W-1:0]           h;
        logic [hrhp_pkg::LEN_W-1:0] clen;
        logic [2:0]                 st;
        logic                       done;
        logic                       have_term;

        in_vld_next   = in_vld_reg;
        in_data_next  = in_data_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        max_len_next  = cfg_we ? cfg_wdata : max_len_reg;

        pos_next      = pos_reg;
        match_next    = match_reg;
        after_nl_next = after_nl_reg;
        name_idx_next = name_idx_reg;
        phase_next    = phase_reg;
        vcnt_next     = vcnt_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        recent_next   = recent_reg;
        since_next    = since_reg;
        found_next    = found_reg;
        term_end_next = term_end_reg;
        text_end_next = text_end_reg;

        b         = in_data_reg.packet_byte;
        lb        = hrhp_pkg::lower8(b);
        stop      = 1'b0;
        do_val    = 1'b0;
        v_phase   = phase_reg;
        v_cnt     = vcnt_reg;
        prod      = '0;
        t_recent  = recent_reg;
        t_since   = since_reg;
        w         = '0;
        n         = '0;
        e         = '0;
        h         = '0;
        clen      = '0;
        st        = hrhp_pkg::ST_OK;
        done      = 1'b0;
        have_term = 1'b0;

        if (in_valid && in_ready)
        begin
            in_vld_next  = 1'b1;
            in_data_next = in_data;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        if (advance)
        begin
            out_vld_next = 1'b0;
        end

        if (proc && pos_reg < POS_W'(PACKET_BYTES))
        begin
            if (pos_reg < POS_W'(hrhp_pkg::LINE_200_LEN)
                && lb != hrhp_pkg::line200_char(pos_reg[4:0]))
            begin
                match_next[0] = 1'b0;
            end
            if (pos_reg < POS_W'(hrhp_pkg::LINE_404_LEN)
                && lb != hrhp_pkg::line404_char(pos_reg[4:0]))
            begin
                match_next[1] = 1'b0;
            end
            if (pos_reg < POS_W'(hrhp_pkg::LINE_503_LEN)
                && lb != hrhp_pkg::line503_char(pos_reg[4:0]))
            begin
                match_next[2] = 1'b0;
            end

            if (!text_end_reg)
            begin
                if (b == hrhp_pkg::CH_NUL)
                begin
                    text_end_next = 1'b1;
                    if (phase_reg != PH_DONE && phase_reg != PH_FAIL)
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_NAME:
                        begin
                            if (after_nl_reg)
                            begin
                                if (name_idx_reg < 4'(hrhp_pkg::NAME_LEN)
                                    && lb == hrhp_pkg::name_char(name_idx_reg))
                                begin
                                    name_idx_next = name_idx_reg + 4'd1;
                                    if (name_idx_reg == 4'(hrhp_pkg::NAME_LEN - 1))
                                    begin
                                        phase_next    = PH_COLON;
                                        after_nl_next = 1'b0;
                                        stop          = 1'b1;
                                    end
                                end
                                else
                                begin
                                    after_nl_next = 1'b0;
                                end
                            end
                            if (!stop && b == hrhp_pkg::CH_LF)
                            begin
                                after_nl_next = 1'b1;
                                name_idx_next = '0;
                            end
                        end
                        PH_COLON:
                        begin
                            if (b == hrhp_pkg::CH_COLON)
                            begin
                                phase_next = PH_SPACE;
                            end
                        end
                        PH_SPACE:
                        begin
                            if (!hrhp_pkg::is_white(b))
                            begin
                                phase_next = PH_DIGITS;
                                do_val     = 1'b1;
                                v_phase    = PH_DIGITS;
                                v_cnt      = '0;
                                t_recent   = '0;
                                t_since    = '0;
                            end
                        end
                        PH_DIGITS, PH_REST:
                        begin
                            do_val = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_val)
                    begin
                        vcnt_next = v_cnt;
                        if (b == hrhp_pkg::CH_LF)
                        begin
                            phase_next = (v_cnt <= CNT_W'(VALUE_CHARS_MAX)) ? PH_DONE
                                                                             : PH_FAIL;
                        end
                        else
                        begin
                            if (v_phase == PH_DIGITS)
                            begin
                                if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE)
                                begin
                                    prod = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1)
                                           + ACC_W'(b - hrhp_pkg::CH_ZERO);
                                    acc_next = (prod > ACC_W'(hrhp_pkg::LEN_SAT))
                                               ? hrhp_pkg::LEN_SAT
                                               : prod[hrhp_pkg::LEN_W-1:0];
                                end
                                else if (v_cnt == '0 && (b == hrhp_pkg::CH_PLUS
                                                         || b == hrhp_pkg::CH_MINUS))
                                begin
                                    neg_next = (b == hrhp_pkg::CH_MINUS);
                                end
                                else
                                begin
                                    phase_next = PH_REST;
                                end
                            end
                            if (v_cnt <= CNT_W'(VALUE_CHARS_MAX))
                            begin
                                vcnt_next = v_cnt + CNT_W'(1);
                            end
                        end
                    end

                    if (phase_next == PH_DIGITS || phase_next == PH_REST
                        || phase_next == PH_DONE)
                    begin
                        w = {t_recent, b};
                        if (!found_reg[0] && t_since >= 2'd1 && w[15:0] == 16'h0A0A)
                        begin
                            found_next[0]    = 1'b1;
                            term_end_next[0] = pos_reg + POS_W'(1);
                        end
                        if (!found_reg[1] && t_since >= 2'd3 && w == 32'h0A0D0A0D)
                        begin
                            found_next[1]    = 1'b1;
                            term_end_next[1] = pos_reg + POS_W'(1);
                        end
                        if (!found_reg[2] && t_since >= 2'd3 && w == 32'h0D0A0D0A)
                        begin
                            found_next[2]    = 1'b1;
                            term_end_next[2] = pos_reg + POS_W'(1);
                        end
                        recent_next = w[23:0];
                        since_next  = (t_since < 2'd3) ? t_since + 2'd1 : t_since;
                    end
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end

        if (proc && in_data_reg.last_byte)
        begin
            n = pos_next;
            if (n < POS_W'(hrhp_pkg::LINE_200_LEN))
            begin
                st = hrhp_pkg::ST_SERVER_ERROR;
            end
            else if (match_next[0])
            begin
                st = hrhp_pkg::ST_OK;
            end
            else if (match_next[1] && n >= POS_W'(hrhp_pkg::LINE_404_LEN))
            begin
                st = hrhp_pkg::ST_NOT_FOUND;
            end
            else if (match_next[2] && n >= POS_W'(hrhp_pkg::LINE_503_LEN))
            begin
                st = hrhp_pkg::ST_BUSY;
            end
            else
            begin
                st = hrhp_pkg::ST_SERVER_ERROR;
            end

            out_data_next.body_offset     = '0;
            out_data_next.body_bytes_here = '0;

            if (st == hrhp_pkg::ST_OK)
            begin
                done = (phase_next == PH_DONE) && !neg_next;
                clen = done ? acc_next : '0;
                have_term = |found_next;
                if (found_next[0])
                begin
                    e = term_end_next[0];
                end
                else if (found_next[1])
                begin
                    e = term_end_next[1];
                end
                else
                begin
                    e = term_end_next[2];
                end
                h = (n >= e) ? n - e : '0;
                if (!done || clen == '0 || !have_term
                    || hrhp_pkg::LEN_W'(h) > clen || clen > max_len_reg)
                begin
                    st = hrhp_pkg::ST_INVALID;
                end
                else
                begin
                    out_data_next.body_offset     = hrhp_pkg::BODY_W'(e);
                    out_data_next.body_bytes_here = hrhp_pkg::BODY_W'(h);
                end
            end

            out_vld_next                 = 1'b1;
            out_data_next.status         = st;
            out_data_next.content_length = clen;

            pos_next         = '0;
            match_next       = 3'b111;
            after_nl_next    = 1'b0;
            name_idx_next    = '0;
            phase_next       = PH_NAME;
            vcnt_next        = '0;
            acc_next         = '0;
            neg_next         = 1'b0;
            recent_next      = '0;
            since_next       = '0;
            found_next       = '0;
            term_end_next[0] = '0;
            term_end_next[1] = '0;
            term_end_next[2] = '0;
            text_end_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            in_data_reg     <= '0;
            out_vld_reg     <= 1'b0;
            out_data_reg    <= '0;
            max_len_reg     <= hrhp_pkg::MAX_LEN_RESET;
            pos_reg         <= '0;
            match_reg       <= 3'b111;
            after_nl_reg    <= 1'b0;
            name_idx_reg    <= '0;
            phase_reg       <= PH_NAME;
            vcnt_reg        <= '0;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            recent_reg      <= '0;
            since_reg       <= '0;
            found_reg       <= '0;
            term_end_reg[0] <= '0;
            term_end_reg[1] <= '0;
            term_end_reg[2] <= '0;
            text_end_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg      <= in_vld_next;
            in_data_reg     <= in_data_next;
            out_vld_reg     <= out_vld_next;
            out_data_reg    <= out_data_next;
            max_len_reg     <= max_len_next;
            pos_reg         <= pos_next;
            match_reg       <= match_next;
            after_nl_reg    <= after_nl_next;
            name_idx_reg    <= name_idx_next;
            phase_reg       <= phase_next;
            vcnt_reg        <= vcnt_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            recent_reg      <= recent_next;
            since_reg       <= since_next;
            found_reg       <= found_next;
            term_end_reg    <= term_end_next;
            text_end_reg    <= text_end_next;
        end
    end

endmodule

// File: design/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks on the result channel of the HTTP response header parser.
// ----------------------------------------------------------------------------
module hrhp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  hrhp_pkg::in_t                in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  hrhp_pkg::out_t               out_data,
    input  logic                         cfg_we,
    input  logic [hrhp_pkg::LEN_W-1:0]   cfg_wdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= hrhp_pkg::ST_INVALID)
        else $error("status code out of range");

    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != hrhp_pkg::ST_OK
        |-> out_data.body_offset == '0 && out_data.body_bytes_here == '0)
        else $error("body fields set on a failed response");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == hrhp_pkg::ST_SERVER_ERROR
                      || out_data.status == hrhp_pkg::ST_NOT_FOUND
                      || out_data.status == hrhp_pkg::ST_BUSY)
        |-> out_data.content_length == '0)
        else $error("content length set on an error status");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == hrhp_pkg::ST_OK
        |-> out_data.content_length != '0
            && hrhp_pkg::LEN_W'(out_data.body_bytes_here) <= out_data.content_length)
        else $error("ok response with bad content length");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);
